[hdl/fenp_pkg.sv]
// Package for the position-string parser: field indexes, error codes, char helpers.
// No dependencies.
package fenp_pkg;

  localparam int unsigned CntW = 31;
  localparam logic [CntW-1:0] IntTop = 31'h7FFF_FFFF;

  typedef enum logic [4:0] {
    ERR_NONE        = 5'd0,
    ERR_FEW_FIELDS  = 5'd1,
    ERR_MANY_FIELDS = 5'd2,
    ERR_SLASH_SHORT = 5'd3,
    ERR_RANK_OVER   = 5'd4,
    ERR_RANK_LONG   = 5'd5,
    ERR_PLACE_CHAR  = 5'd6,
    ERR_PLACE_END   = 5'd7,
    ERR_SIDE        = 5'd8,
    ERR_CASTLE_REP  = 5'd9,
    ERR_CASTLE_CHAR = 5'd10,
    ERR_EP_LEN      = 5'd11,
    ERR_EP_FILE     = 5'd12,
    ERR_EP_RANK     = 5'd13,
    ERR_HALF_DIGIT  = 5'd14,
    ERR_HALF_BIG    = 5'd15,
    ERR_FULL_DIGIT  = 5'd16,
    ERR_FULL_BIG    = 5'd17,
    ERR_FULL_ZERO   = 5'd18
  } err_t;

  // field indexes (field_count - 1)
  localparam logic [2:0] FldPlace  = 3'd0;
  localparam logic [2:0] FldSide   = 3'd1;
  localparam logic [2:0] FldCastle = 3'd2;
  localparam logic [2:0] FldEp     = 3'd3;
  localparam logic [2:0] FldHalf   = 3'd4;
  localparam logic [2:0] FldFull   = 3'd5;

  // piece kind from lowercase letter; bit 3 set means no piece
  function automatic logic [3:0] piece_kind(input logic [7:0] c);
    logic [3:0] k;
    unique case (c)
      "k": k = 4'd0;
      "q": k = 4'd1;
      "r": k = 4'd2;
      "b": k = 4'd3;
      "n": k = 4'd4;
      "p": k = 4'd5;
      default: k = 4'd8;
    endcase
    return k;
  endfunction

endpackage

[hdl/fen_position_parser.sv]
// Top level of the position-string parser, one byte per beat.
// Depends on fenp_pkg.
//
// Usage:
//  Input channel (in_valid/in_ready, in_byte, in_last_byte) carries one
//  character of a position string per beat; the final character is marked.
//  Output channel (out_valid/out_ready) gives exactly one result beat per
//  input beat: a square write when the byte is a piece letter of the
//  placement field, and on the final byte the summary (side, castling,
//  en passant, move counters, error code).
//  The result of a byte accepted at one edge is on the output from the next
//  cycle. Throughput is one byte per cycle while results are taken; the
//  parse state and the output register update in the same cycle.
//  If the receiver stalls, the output register holds and in_ready drops
//  only while a full result is waiting and not being taken.
//  Reset (rst_n low, synchronous) empties the output register and returns
//  the parse state to the start of a string, as does every final byte.
//  The consumer clears its board before a string and drops the writes
//  when error_code is nonzero.
module fen_position_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_place_valid,
  output logic [5:0]  out_square_index,
  output logic [3:0]  out_piece_code,
  output logic        out_done_res,
  output logic [4:0]  out_error_code,
  output logic        out_side_black,
  output logic [3:0]  out_castle_bits,
  output logic        out_ep_valid,
  output logic [5:0]  out_ep_square,
  output logic [30:0] out_halfmove_count,
  output logic [30:0] out_fullmove_count
);
  import fenp_pkg::*;

  // parse state
  logic [2:0]      field_count_r, field_count_nxt;
  logic            in_token_r, in_token_nxt;
  logic [3:0]      board_file_r, board_file_nxt;
  logic [3:0]      board_rank_r, board_rank_nxt;
  logic [4:0]      sticky_error_r, sticky_error_nxt;
  logic [7:0]      side_char_r, side_char_nxt;
  logic [1:0]      side_length_r, side_length_nxt;
  logic [3:0]      castle_seen_r, castle_seen_nxt;
  logic            castle_dash_r, castle_dash_nxt;
  logic [15:0]     ep_chars_r, ep_chars_nxt;
  logic [1:0]      ep_length_r, ep_length_nxt;
  logic [CntW-1:0] half_r, half_nxt;
  logic [CntW-1:0] full_r, full_nxt;

  // output register
  logic            out_valid_r;
  logic            place_r, done_r, side_r, epv_r;
  logic [5:0]      sq_r, epsq_r;
  logic [3:0]      piece_r, castle_r;
  logic [4:0]      err_r;
  logic [CntW-1:0] half_out_r, full_out_r;

  logic accept;
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // en passant check on a given state
  function automatic logic [4:0] ep_err(input logic [1:0] len, input logic [15:0] ch);
    logic [4:0] e;
    if (len == 2'd1 && ch[7:0] == "-") e = ERR_NONE;
    else if (len != 2'd2) e = ERR_EP_LEN;
    else if (ch[7:0] < "a" || ch[7:0] > "h") e = ERR_EP_FILE;
    else if (ch[15:8] != "3" && ch[15:8] != "6") e = ERR_EP_RANK;
    else e = ERR_NONE;
    return e;
  endfunction

  // checks made when a field ends
  function automatic logic [4:0] end_err(
    input logic [2:0] idx, input logic [3:0] rank, input logic [3:0] file,
    input logic [1:0] slen, input logic [7:0] sch,
    input logic [1:0] elen, input logic [15:0] ech, input logic [CntW-1:0] fv);
    logic [4:0] e;
    e = ERR_NONE;
    unique case (idx)
      FldPlace: if (rank != 4'd0 || file != 4'd8) e = ERR_PLACE_END;
      FldSide:  if (slen != 2'd1 || (sch != "w" && sch != "b")) e = ERR_SIDE;
      FldEp:    e = ep_err(elen, ech);
      FldFull:  if (fv == '0) e = ERR_FULL_ZERO;
      default:  e = ERR_NONE;
    endcase
    return e;
  endfunction

  // per-byte decode
  logic            ws, tok_start, content;
  logic [2:0]      fc_now, idx;
  logic [4:0]      cerr, eerr, fin_err;
  logic            place;
  logic [5:0]      sq;
  logic [3:0]      piece, kind, cbit;
  logic [7:0]      lower;
  logic            upper;
  logic [4:0]      fsum;
  logic [3:0]      dig;
  logic            is_dig;
  logic [CntW-1:0] num_in, num_lim, num_upd;
  logic [CntW+3:0] num_x10;
  logic [4:0]      err_final;
  logic            last_tok;

  always_comb begin
    ws        = (in_byte == 8'h20) || (in_byte >= 8'd9 && in_byte <= 8'd13);
    tok_start = !ws && !in_token_r;
    fc_now    = (tok_start && field_count_r != 3'd7) ? field_count_r + 3'd1 : field_count_r;
    idx       = fc_now - 3'd1;
    content   = !ws && fc_now <= 3'd6 && sticky_error_r == ERR_NONE;

    field_count_nxt  = fc_now;
    in_token_nxt     = !ws;
    board_file_nxt   = board_file_r;
    board_rank_nxt   = board_rank_r;
    side_char_nxt    = side_char_r;
    side_length_nxt  = side_length_r;
    castle_seen_nxt  = castle_seen_r;
    castle_dash_nxt  = castle_dash_r;
    ep_chars_nxt     = ep_chars_r;
    ep_length_nxt    = ep_length_r;
    half_nxt         = half_r;
    full_nxt         = full_r;
    cerr             = ERR_NONE;
    place            = 1'b0;
    sq               = '0;
    piece            = '0;

    upper  = in_byte >= "A" && in_byte <= "Z";
    lower  = upper ? (in_byte | 8'h20) : in_byte;
    kind   = piece_kind(lower);
    fsum   = {1'b0, board_file_r} + {1'b0, in_byte[3:0]};
    is_dig = in_byte >= "0" && in_byte <= "9";
    dig    = in_byte[3:0];
    num_in = (idx == FldHalf) ? half_r : full_r;
    // v*10+d <= top  <=>  v <= (top-d)/10 ; compute via widened product
    num_x10 = {4'd0, num_in} * 35'd10 + {31'd0, dig};
    num_lim = num_x10[CntW-1:0];
    num_upd = num_lim;

    unique case (in_byte)
      "K": cbit = 4'd1;
      "Q": cbit = 4'd2;
      "k": cbit = 4'd4;
      "q": cbit = 4'd8;
      default: cbit = 4'd0;
    endcase

    if (content) begin
      unique case (idx)
        FldPlace: begin
          if (in_byte == "/") begin
            if (board_file_r != 4'd8) cerr = ERR_SLASH_SHORT;
            else if (board_rank_r == 4'd0) cerr = ERR_RANK_OVER;
            else begin
              board_rank_nxt = board_rank_r - 4'd1;
              board_file_nxt = '0;
            end
          end else if (in_byte >= "1" && in_byte <= "8") begin
            if (fsum > 5'd8) cerr = ERR_RANK_LONG;
            else board_file_nxt = fsum[3:0];
          end else if (kind[3]) begin
            cerr = ERR_PLACE_CHAR;
          end else if (board_file_r >= 4'd8) begin
            cerr = ERR_RANK_LONG;
          end else begin
            place = 1'b1;
            sq    = {board_rank_r[2:0], board_file_r[2:0]};
            piece = upper ? kind : kind + 4'd6;
            board_file_nxt = board_file_r + 4'd1;
          end
        end
        FldSide: begin
          if (side_length_r == 2'd0) side_char_nxt = in_byte;
          if (side_length_r != 2'd3) side_length_nxt = side_length_r + 2'd1;
        end
        FldCastle: begin
          if (castle_dash_r) cerr = ERR_CASTLE_CHAR;
          else if (in_byte == "-") begin
            if (castle_seen_r == 4'd0) castle_dash_nxt = 1'b1;
            else cerr = ERR_CASTLE_CHAR;
          end else if (cbit == 4'd0) cerr = ERR_CASTLE_CHAR;
          else if ((castle_seen_r & cbit) != 4'd0) cerr = ERR_CASTLE_REP;
          else castle_seen_nxt = castle_seen_r | cbit;
        end
        FldEp: begin
          if (ep_length_r == 2'd0) ep_chars_nxt[7:0] = in_byte;
          else if (ep_length_r == 2'd1) ep_chars_nxt[15:8] = in_byte;
          if (ep_length_r != 2'd3) ep_length_nxt = ep_length_r + 2'd1;
        end
        FldHalf, FldFull: begin
          if (!is_dig) cerr = (idx == FldHalf) ? ERR_HALF_DIGIT : ERR_FULL_DIGIT;
          else if (num_x10[CntW+3:CntW] != 4'd0 || num_lim > IntTop)
            cerr = (idx == FldHalf) ? ERR_HALF_BIG : ERR_FULL_BIG;
          else if (idx == FldHalf) half_nxt = num_upd;
          else full_nxt = num_upd;
        end
        default: ;
      endcase
    end

    // field end on whitespace after a token (state before this byte)
    eerr = ERR_NONE;
    if (ws && in_token_r && field_count_r <= 3'd6 && sticky_error_r == ERR_NONE)
      eerr = end_err(field_count_r - 3'd1, board_rank_r, board_file_r, side_length_r,
                     side_char_r, ep_length_r, ep_chars_r, full_r);

    sticky_error_nxt = sticky_error_r;
    if (sticky_error_r == ERR_NONE) sticky_error_nxt = (cerr != ERR_NONE) ? cerr : eerr;

    // final byte: close an open field with updated state
    last_tok = in_token_nxt && field_count_nxt <= 3'd6 && sticky_error_nxt == ERR_NONE;
    fin_err  = last_tok ? end_err(field_count_nxt - 3'd1, board_rank_nxt, board_file_nxt,
                                  side_length_nxt, side_char_nxt, ep_length_nxt,
                                  ep_chars_nxt, full_nxt) : ERR_NONE;
    if (field_count_nxt < 3'd6) err_final = ERR_FEW_FIELDS;
    else if (field_count_nxt > 3'd6) err_final = ERR_MANY_FIELDS;
    else if (sticky_error_nxt != ERR_NONE) err_final = sticky_error_nxt;
    else err_final = fin_err;
  end

  // state and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r    <= 1'b0;
      field_count_r  <= '0;
      in_token_r     <= 1'b0;
      board_file_r   <= '0;
      board_rank_r   <= 4'd7;
      sticky_error_r <= ERR_NONE;
      side_char_r    <= '0;
      side_length_r  <= '0;
      castle_seen_r  <= '0;
      castle_dash_r  <= 1'b0;
      ep_chars_r     <= '0;
      ep_length_r    <= '0;
      half_r         <= '0;
      full_r         <= '0;
    end else begin
      if (accept) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (accept) begin
        if (in_last_byte) begin
          field_count_r  <= '0;
          in_token_r     <= 1'b0;
          board_file_r   <= '0;
          board_rank_r   <= 4'd7;
          sticky_error_r <= ERR_NONE;
          side_char_r    <= '0;
          side_length_r  <= '0;
          castle_seen_r  <= '0;
          castle_dash_r  <= 1'b0;
          ep_chars_r     <= '0;
          ep_length_r    <= '0;
          half_r         <= '0;
          full_r         <= '0;
        end else begin
          field_count_r  <= field_count_nxt;
          in_token_r     <= in_token_nxt;
          board_file_r   <= board_file_nxt;
          board_rank_r   <= board_rank_nxt;
          sticky_error_r <= sticky_error_nxt;
          side_char_r    <= side_char_nxt;
          side_length_r  <= side_length_nxt;
          castle_seen_r  <= castle_seen_nxt;
          castle_dash_r  <= castle_dash_nxt;
          ep_chars_r     <= ep_chars_nxt;
          ep_length_r    <= ep_length_nxt;
          half_r         <= half_nxt;
          full_r         <= full_nxt;
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      place_r    <= place;
      sq_r       <= sq;
      piece_r    <= piece;
      done_r     <= in_last_byte;
      err_r      <= in_last_byte ? err_final : ERR_NONE;
      if (in_last_byte && err_final == ERR_NONE) begin
        side_r     <= side_char_nxt == "b";
        castle_r   <= castle_seen_nxt;
        epv_r      <= ep_chars_nxt[7:0] != "-";
        epsq_r     <= (ep_chars_nxt[7:0] != "-") ?
                      {ep_chars_nxt[10:8] - 3'd1, ep_chars_nxt[2:0] - 3'd1} : 6'd0;
        half_out_r <= half_nxt;
        full_out_r <= full_nxt;
      end else begin
        side_r     <= 1'b0;
        castle_r   <= '0;
        epv_r      <= 1'b0;
        epsq_r     <= '0;
        half_out_r <= '0;
        full_out_r <= '0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_place_valid    = place_r;
  assign out_square_index   = sq_r;
  assign out_piece_code     = piece_r;
  assign out_done_res       = done_r;
  assign out_error_code     = err_r;
  assign out_side_black     = side_r;
  assign out_castle_bits    = castle_r;
  assign out_ep_valid       = epv_r;
  assign out_ep_square      = epsq_r;
  assign out_halfmove_count = half_out_r;
  assign out_fullmove_count = full_out_r;

endmodule

[hdl/fenp_checker.sv]
// Port-level checks for the position-string parser, bound to the top level.
// Depends on fenp_pkg.
module fenp_props (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_place_valid,
  input logic       out_done_res,
  input logic [4:0] out_error_code,
  input logic [3:0] out_castle_bits
);
  import fenp_pkg::*;

  // every accepted beat shows a result next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid) else $error("missing result beat");

  // a waiting result blocks input
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready) else $error("input taken over stalled result");

  // error codes only on the final beat
  a_err_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done_res |-> out_error_code == ERR_NONE)
    else $error("error code without done");

  // summary stays zero on error (checked on the castle bits)
  a_summary_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_code != ERR_NONE |-> out_castle_bits == 4'd0)
    else $error("summary set on error");

  // output register empties after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result after reset");

  // unused in checks beyond payload presence
  logic unused_place;
  assign unused_place = out_place_valid;

endmodule

bind fen_position_parser fenp_props u_fenp_props (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_place_valid(out_place_valid),
  .out_done_res(out_done_res), .out_error_code(out_error_code),
  .out_castle_bits(out_castle_bits)
);

[tb/fenp_checker.sv]
// Checker for fen_position_parser: watches both channels, predicts each result beat
// and compares it field by field. Depends on fenp_pkg.
`timescale 1ns / 1ps
module fenp_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_place_valid,
  input  logic [5:0]  out_square_index,
  input  logic [3:0]  out_piece_code,
  input  logic        out_done_res,
  input  logic [4:0]  out_error_code,
  input  logic        out_side_black,
  input  logic [3:0]  out_castle_bits,
  input  logic        out_ep_valid,
  input  logic [5:0]  out_ep_square,
  input  logic [30:0] out_halfmove_count,
  input  logic [30:0] out_fullmove_count,
  output int          fail_count,
  output int          pending
);
  import fenp_pkg::*;

  typedef struct packed {
    logic        place;
    logic [5:0]  square;
    logic [3:0]  piece;
    logic        done;
    logic [4:0]  err;
    logic        black;
    logic [3:0]  castle;
    logic        ep_given;
    logic [5:0]  ep_sq;
    logic [30:0] halfmove;
    logic [30:0] fullmove;
  } fen_beat_t;

  fen_beat_t expected_beats[$];

  // parse state of the string in flight
  logic [2:0]  fields_seen;
  logic        in_field;
  logic [3:0]  file_pos;
  logic [3:0]  rank_pos;
  err_t        first_err;
  logic [7:0]  side_ch;
  logic [1:0]  side_len;
  logic [3:0]  rights;
  logic        rights_dash;
  logic [7:0]  ep_c0, ep_c1;
  logic [1:0]  ep_len;
  logic [31:0] half_acc, full_acc;

  task automatic clear_parse();
    fields_seen = '0; in_field = 1'b0; file_pos = '0; rank_pos = 4'd7;
    first_err = ERR_NONE; side_ch = '0; side_len = '0; rights = '0;
    rights_dash = 1'b0; ep_c0 = '0; ep_c1 = '0; ep_len = '0;
    half_acc = '0; full_acc = '0;
  endtask

  task automatic note_err(input err_t code);
    if (first_err == ERR_NONE) first_err = code;
  endtask

  task automatic ep_eval(output logic given, output logic [5:0] sq, output err_t e);
    logic [7:0] idx;
    given = 1'b0; sq = '0; e = ERR_NONE;
    if (ep_len == 2'd1 && ep_c0 == "-") return;
    if (ep_len != 2'd2) e = ERR_EP_LEN;
    else if (ep_c0 < "a" || ep_c0 > "h") e = ERR_EP_FILE;
    else if (ep_c1 != "3" && ep_c1 != "6") e = ERR_EP_RANK;
    else begin
      given = 1'b1;
      idx = (ep_c1 - "1") * 8 + (ep_c0 - "a");
      sq = idx[5:0];
    end
  endtask

  // decimal accumulate with overflow check against 2^31-1
  task automatic add_digit(inout logic [31:0] v, input logic [7:0] c,
                           input err_t bad, input err_t big);
    logic [31:0] d;
    if (c < "0" || c > "9") begin
      note_err(bad);
      return;
    end
    d = {24'd0, c - 8'h30};
    if (v > (32'h7FFF_FFFF - d) / 10) begin
      note_err(big);
      return;
    end
    v = v * 10 + d;
  endtask

  function automatic int kind_of(input logic [7:0] l);
    case (l)
      "k": return 0;
      "q": return 1;
      "r": return 2;
      "b": return 3;
      "n": return 4;
      "p": return 5;
      default: return -1;
    endcase
  endfunction

  task automatic board_char(input logic [7:0] c, inout fen_beat_t r);
    logic [4:0] f;
    logic       upper;
    logic [7:0] low;
    int         k;
    if (c == "/") begin
      if (file_pos != 4'd8) note_err(ERR_SLASH_SHORT);
      else if (rank_pos == 4'd0) note_err(ERR_RANK_OVER);
      else begin
        rank_pos--;
        file_pos = '0;
      end
    end else if (c >= "1" && c <= "8") begin
      f = {1'b0, file_pos} + {1'b0, c[3:0]};
      if (f > 5'd8) note_err(ERR_RANK_LONG);
      else file_pos = f[3:0];
    end else begin
      upper = (c >= "A" && c <= "Z");
      low = upper ? (c | 8'h20) : c;
      k = kind_of(low);
      if (k < 0) note_err(ERR_PLACE_CHAR);
      else if (file_pos >= 4'd8) note_err(ERR_RANK_LONG);
      else begin
        r.place = 1'b1;
        r.square = {rank_pos[2:0], file_pos[2:0]};
        r.piece = 4'(k + (upper ? 0 : 6));
        file_pos++;
      end
    end
  endtask

  task automatic rights_char(input logic [7:0] c);
    logic [3:0] b;
    if (rights_dash) begin
      note_err(ERR_CASTLE_CHAR);
      return;
    end
    case (c)
      "K": b = 4'd1;
      "Q": b = 4'd2;
      "k": b = 4'd4;
      "q": b = 4'd8;
      "-": begin
        if (rights == 4'd0) rights_dash = 1'b1;
        else note_err(ERR_CASTLE_CHAR);
        return;
      end
      default: begin
        note_err(ERR_CASTLE_CHAR);
        return;
      end
    endcase
    if ((rights & b) != 0) note_err(ERR_CASTLE_REP);
    else rights |= b;
  endtask

  task automatic field_char(input logic [2:0] idx, input logic [7:0] c,
                            inout fen_beat_t r);
    if (first_err != ERR_NONE) return;
    case (idx)
      FldPlace: board_char(c, r);
      FldSide: begin
        if (side_len == 2'd0) side_ch = c;
        if (side_len < 2'd3) side_len++;
      end
      FldCastle: rights_char(c);
      FldEp: begin
        if (ep_len == 2'd0) ep_c0 = c;
        else if (ep_len == 2'd1) ep_c1 = c;
        if (ep_len < 2'd3) ep_len++;
      end
      FldHalf: add_digit(half_acc, c, ERR_HALF_DIGIT, ERR_HALF_BIG);
      FldFull: add_digit(full_acc, c, ERR_FULL_DIGIT, ERR_FULL_BIG);
      default: ;
    endcase
  endtask

  task automatic field_close(input logic [2:0] idx);
    logic       g;
    logic [5:0] s;
    err_t       e;
    if (first_err != ERR_NONE) return;
    case (idx)
      FldPlace: if (rank_pos != 4'd0 || file_pos != 4'd8) note_err(ERR_PLACE_END);
      FldSide:
        if (side_len != 2'd1 || (side_ch != "w" && side_ch != "b")) note_err(ERR_SIDE);
      FldEp: begin
        ep_eval(g, s, e);
        if (e != ERR_NONE) note_err(e);
      end
      FldFull: if (full_acc < 1) note_err(ERR_FULL_ZERO);
      default: ;
    endcase
  endtask

  // one byte through the parser, giving the beat it should produce
  task automatic parse_byte(input logic [7:0] c, input logic fin, output fen_beat_t r);
    logic       ws, g;
    logic [5:0] s;
    err_t       e, verdict;
    r = '0;
    ws = (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
    if (ws) begin
      if (in_field) begin
        field_close(fields_seen - 3'd1);
        in_field = 1'b0;
      end
    end else begin
      if (!in_field) begin
        in_field = 1'b1;
        if (fields_seen < 3'd7) fields_seen++;
      end
      if (fields_seen <= 3'd6) field_char(fields_seen - 3'd1, c, r);
    end
    if (fin) begin
      if (in_field && fields_seen <= 3'd6) field_close(fields_seen - 3'd1);
      verdict = fields_seen < 3'd6 ? ERR_FEW_FIELDS :
                (fields_seen > 3'd6 ? ERR_MANY_FIELDS : first_err);
      r.done = 1'b1;
      r.err = verdict;
      if (verdict == ERR_NONE) begin
        ep_eval(g, s, e);
        r.black = (side_ch == "b");
        r.castle = rights;
        r.ep_given = g;
        r.ep_sq = s;
        r.halfmove = half_acc[30:0];
        r.fullmove = full_acc[30:0];
      end
      clear_parse();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
    clear_parse();
  end

  always @(posedge clk) begin
    fen_beat_t exp_b, nxt;
    if (!rst_n) begin
      clear_parse();
      expected_beats.delete();
    end else begin
      // result side first: a beat taken now belongs to an earlier byte
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          report_mismatch("unexpected result beat", 0, 0);
        end else begin
          exp_b = expected_beats.pop_front();
          if (out_place_valid != exp_b.place)
            report_mismatch("place_valid", out_place_valid, exp_b.place);
          if (out_square_index != exp_b.square)
            report_mismatch("square_index", out_square_index, exp_b.square);
          if (out_piece_code != exp_b.piece)
            report_mismatch("piece_code", out_piece_code, exp_b.piece);
          if (out_done_res != exp_b.done)
            report_mismatch("done_res", out_done_res, exp_b.done);
          if (out_error_code != exp_b.err)
            report_mismatch("error_code", out_error_code, exp_b.err);
          if (out_side_black != exp_b.black)
            report_mismatch("side_black", out_side_black, exp_b.black);
          if (out_castle_bits != exp_b.castle)
            report_mismatch("castle_bits", out_castle_bits, exp_b.castle);
          if (out_ep_valid != exp_b.ep_given)
            report_mismatch("ep_valid", out_ep_valid, exp_b.ep_given);
          if (out_ep_square != exp_b.ep_sq)
            report_mismatch("ep_square", out_ep_square, exp_b.ep_sq);
          if (out_halfmove_count != exp_b.halfmove)
            report_mismatch("halfmove_count", out_halfmove_count, exp_b.halfmove);
          if (out_fullmove_count != exp_b.fullmove)
            report_mismatch("fullmove_count", out_fullmove_count, exp_b.fullmove);
        end
      end
      if (in_valid && in_ready) begin
        parse_byte(in_byte, in_last_byte, nxt);
        expected_beats.push_back(nxt);
      end
    end
    pending = expected_beats.size();
  end

endmodule

[tb/tb_top.sv]
// Top of the fen_position_parser testbench: clock, reset, position-string stimulus
// and verdict. Depends on fenp_pkg, fenp_checker and the parser RTL.
`timescale 1ns / 1ps
module tb_top;
  import fenp_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_ready;
  logic        out_place_valid;
  logic [5:0]  out_square_index;
  logic [3:0]  out_piece_code;
  logic        out_done_res;
  logic [4:0]  out_error_code;
  logic        out_side_black;
  logic [3:0]  out_castle_bits;
  logic        out_ep_valid;
  logic [5:0]  out_ep_square;
  logic [30:0] out_halfmove_count;
  logic [30:0] out_fullmove_count;
  int          fail_count;
  int          pending;

  int          send_idle_pct;
  int          recv_stall_pct;
  logic        hold_req;
  logic        hold_done;
  int          hold_left;
  int          bytes_sent;
  logic [7:0]  text_q[$];

  fen_position_parser dut (.*);

  fenp_checker u_checker (.*);

  initial begin
    clk = 1'b0;
  end
  always #6 clk = ~clk;

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= 300;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(1, 100) > recv_stall_pct);
    end
  end

  initial begin
    #20_000_000;
    $display("fen_position_parser test failed");
    $finish;
  end

  task automatic send_beat(input logic [7:0] b, input logic fin);
    int gap;
    if (send_idle_pct > 0 && $urandom_range(1, 100) <= send_idle_pct) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_last_byte <= fin;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_beat(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic put_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic send_str(input string s);
    put_str(s);
    send_text();
  endtask

  task automatic put_gap();
    int n;
    logic [7:0] w;
    n = $urandom_range(1, 3);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: w = 8'd9;
        1: w = 8'd10;
        2: w = 8'd11;
        3: w = 8'd12;
        4: w = 8'd13;
        default: w = 8'h20;
      endcase
      text_q.push_back(w);
    end
  endtask

  // move counter text: mostly small, sometimes around or well above the 31-bit limit
  task automatic put_count(input logic allow_zero);
    longint v;
    case ($urandom_range(0, 9))
      0: v = 64'd2147483640 + $urandom_range(0, 15);
      1: v = $urandom_range(0, 32'hFFFF_FFFF) * 64'd3;
      2: v = $urandom_range(0, 32'h7FFF_FFFF);
      default: v = $urandom_range(allow_zero ? 0 : 1, 150);
    endcase
    put_str($sformatf("%0d", v));
  endtask

  // a position with random content (move counters may be zero or too big), then optional damage
  task automatic build_position();
    string pieces;
    int f, n, pos, k;
    logic [3:0] m;
    pieces = "KQRBNPkqrbnp";
    if ($urandom_range(0, 7) == 0) put_gap();
    for (int r = 0; r < 8; r++) begin
      f = 0;
      while (f < 8) begin
        if ($urandom_range(0, 2) == 0) begin
          n = $urandom_range(1, 8 - f);
          text_q.push_back(8'(8'h30 + n));
          f += n;
        end else begin
          text_q.push_back(pieces[$urandom_range(0, 11)]);
          f++;
        end
      end
      if (r < 7) text_q.push_back("/");
    end
    put_gap();
    put_str($urandom_range(0, 1) ? "w" : "b");
    put_gap();
    m = 4'($urandom_range(0, 15));
    if (m == 0) put_str("-");
    else begin
      if (m[0]) put_str("K");
      if (m[1]) put_str("Q");
      if (m[2]) put_str("k");
      if (m[3]) put_str("q");
    end
    put_gap();
    if ($urandom_range(0, 1)) put_str("-");
    else begin
      text_q.push_back(8'("a" + $urandom_range(0, 7)));
      put_str($urandom_range(0, 1) ? "3" : "6");
    end
    put_gap();
    put_count(1'b1);
    put_gap();
    put_count($urandom_range(0, 9) == 0);
    if ($urandom_range(0, 7) == 0) put_gap();
    if ($urandom_range(0, 99) < 30) begin
      k = $urandom_range(1, 2);
      repeat (k) begin
        pos = $urandom_range(0, text_q.size() - 1);
        case ($urandom_range(0, 2))
          0: text_q[pos] = 8'($urandom_range(0, 255));
          1: if (text_q.size() > 1) text_q.delete(pos);
          default: text_q.insert(pos, 8'($urandom_range(0, 255)));
        endcase
      end
    end
  endtask

  task automatic build_noise();
    int n;
    n = $urandom_range(1, 12);
    repeat (n) text_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // wait for every expected result, sampling the count away from the edge
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic random_phase(input int idle, input int stall, input int quota);
    int stop_at;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    stop_at = bytes_sent + quota;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) build_noise();
      else build_position();
      send_text();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte = '0;
    in_last_byte = 1'b0;
    hold_req = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    bytes_sent = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed strings: legal extremes and each error class
    send_str("rnbqkbnr/pppppppp/8/8/8/8/PPPPPPPP/RNBQKBNR w KQkq - 0 1");
    send_str("8/8/8/8/8/8/8/8 b - e3 2147483647 2147483647");
    send_str("\t 8/8/8/8/8/8/8/8 w Qk h6 0 1 \r");
    send_str("k7/8/8/8/8/8/8/7K w - - 2147483648 1");
    send_str("8/8/8/8/8/8/8/8 w - a6 0 2147483648");
    send_str("8/8/8/8/8/8/8/8 w - - 0 0");
    send_str("8/8/8/8/8/8/8/8 w - - 0 1x");
    send_str("8/8/8/8/8/8/8/8 w - - 1x 1");
    send_str("8/8 w - - 0 1");
    send_str("7/8/8/8/8/8/8/8 w - - 0 1");
    send_str("8/8/8/8/8/8/8/8/8 w - - 0 1");
    send_str("8p/8/8/8/8/8/8/8 w - - 0 1");
    send_str("x7/8/8/8/8/8/8/8 w - - 0 1");
    send_str("8/8/8/8/8/8/8/8 ww - - 0 1");
    send_str("8/8/8/8/8/8/8/8 w KK - 0 1");
    send_str("8/8/8/8/8/8/8/8 w -K - 0 1");
    send_str("8/8/8/8/8/8/8/8 w x - 0 1");
    send_str("8/8/8/8/8/8/8/8 w - e 0 1");
    send_str("8/8/8/8/8/8/8/8 w - i3 0 1");
    send_str("8/8/8/8/8/8/8/8 w - e4 0 1");
    send_str("8/8/8/8/8/8/8/8 w");
    send_str("8/8/8/8/8/8/8/8 w - - 0 1 junk 9");
    text_q.push_back(8'hFF);
    text_q.push_back(8'h80);
    send_text();

    // receiver holds off for a long stretch while bytes keep coming
    hold_req = 1'b1;
    random_phase(0, 0, 120);
    drain();
    random_phase(67, 0, 120);
    drain();
    random_phase(0, 67, 120);
    drain();
    random_phase(18, 18, 120);

    drain();
    repeat (5) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("fen_position_parser test passed");
    end else begin
      $display("fen_position_parser test failed");
    end
    $finish;
  end

endmodule

[fen_position_parser.f]
hdl/fenp_pkg.sv
hdl/fen_position_parser.sv
hdl/fenp_checker.sv
tb/fenp_checker.sv
tb/tb_top.sv
